// ===== hw/rtl/ordl_pkg.sv =====
`default_nettype none

package ordl_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VAL_W = 32;

   typedef enum logic [1:0] {
      CMD_HEAD   = 2'd0,
      CMD_TAIL   = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_HEAD   = 3'd1,
      OP_TAIL   = 3'd2,
      OP_DELETE = 3'd3,
      OP_ROTATE = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [VAL_W-1:0]  key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ordl_cell.sv =====
`default_nettype none

module ordl_cell (
   input  wire logic                       clock,
   input  wire ordl_pkg::cell_ctrl_type    ctrl,
   input  wire logic                       occ,
   input  wire logic                       left_occ,
   input  wire logic                       right_occ,
   input  wire logic [ordl_pkg::VAL_W-1:0] left_value,
   input  wire logic [ordl_pkg::VAL_W-1:0] right_value,
   input  wire logic [ordl_pkg::VAL_W-1:0] head_value,
   input  wire logic                       hit_in,
   output logic      [ordl_pkg::VAL_W-1:0] value,
   output logic                            hit_out
);

   logic [ordl_pkg::VAL_W-1:0] value_ff;
   logic [ordl_pkg::VAL_W-1:0] value_in;
   logic                       match;

   assign match   = occ && (value_ff == ctrl.key);
   assign hit_out = hit_in || match;
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         ordl_pkg::OP_HEAD: begin
            value_in = left_value;
         end
         ordl_pkg::OP_TAIL: begin
            // first free cell takes the new word
            if (left_occ && !occ) begin
               value_in = ctrl.key;
            end
         end
         ordl_pkg::OP_DELETE: begin
            if (hit_out) begin
               value_in = right_value;
            end
         end
         ordl_pkg::OP_ROTATE: begin
            // tail entry wraps around to take the head
            if (right_occ) begin
               value_in = right_value;
            end else if (occ) begin
               value_in = head_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_engine_core.sv =====
`default_nettype none

// Ordered list of up to 16 signed 32-bit words, kept in a row of cells.
// Command channel: req_cmd and req_value are taken at a clock edge where
// start is high and busy is low. Commands: insert at head, insert at tail,
// delete first equal word searching from the head, and dump.
// Result channel: rsp_valid marks one word on rsp_item_value, rsp_status and
// rsp_last for exactly one cycle; the receiver cannot stall it.
// Insert and delete need no busy phase: their single status word appears
// the cycle after acceptance, and busy stays low, so a command can follow in
// the next cycle. A delete compares all cells in parallel and the matching
// cell and those behind it shift one place toward the head.
// Dump emits one word per cycle from head to tail, starting the cycle after
// acceptance; the cells rotate one place per word, so a dump keeps busy
// high until its last word is registered and leaves the list as it
// was. An empty dump gives a single empty-status word.
// Reset empties the list; cell contents are not cleared.

module ordered_list_engine_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_cmd,
   input  wire logic [31:0]                req_value,
   output logic                            rsp_valid,
   output logic      [31:0]                rsp_item_value,
   output logic      [1:0]                 rsp_status,
   output logic                            rsp_last
);

   localparam int N = ordl_pkg::CAPACITY;
   localparam int CW = ordl_pkg::CNT_W;

   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [CW-1:0]              remaining_ff;
   logic [CW-1:0]              remaining_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [31:0]                item_ff;
   logic [31:0]                item_in;
   ordl_pkg::status_type       status_ff;
   ordl_pkg::status_type       status_in;
   logic                       last_ff;
   logic                       last_in;

   ordl_pkg::cell_ctrl_type    ctrl;
   logic                       accept;
   logic                       full;
   logic                       found;
   logic [N:0]                 occ;
   logic [N:0]                 hit;
   logic [31:0]                cell_value [N+1];

   assign accept = start && !busy;
   assign busy   = (remaining_ff != '0);
   assign full   = (count_ff == CW'(N));
   assign found  = hit[N];

   assign hit[0]        = 1'b0;
   assign cell_value[N] = '0;
   assign occ[N]        = 1'b0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign occ[i] = (CW'(i) < count_ff);

      ordl_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occ         (occ[i]),
         .left_occ    ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
         .right_occ   (occ[i+1]),
         .left_value  ((i == 0) ? req_value : cell_value[(i == 0) ? 0 : i-1]),
         .right_value (cell_value[i+1]),
         .head_value  (cell_value[0]),
         .hit_in      (hit[i]),
         .value       (cell_value[i]),
         .hit_out     (hit[i+1])
      );
   end

   always_comb begin
      ctrl.key     = req_value;
      ctrl.op      = ordl_pkg::OP_NONE;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      rsp_valid_in = 1'b0;
      item_in      = '0;
      status_in    = ordl_pkg::ST_OK;
      last_in      = 1'b1;
      if (busy) begin
         ctrl.op      = ordl_pkg::OP_ROTATE;
         rsp_valid_in = 1'b1;
         item_in      = cell_value[0];
         last_in      = (remaining_ff == CW'(1));
         remaining_in = remaining_ff - CW'(1);
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (ordl_pkg::cmd_type'(req_cmd))
            ordl_pkg::CMD_HEAD, ordl_pkg::CMD_TAIL: begin
               if (full) begin
                  status_in = ordl_pkg::ST_FULL;
               end else begin
                  ctrl.op  = (ordl_pkg::cmd_type'(req_cmd) == ordl_pkg::CMD_HEAD) ?
                             ordl_pkg::OP_HEAD : ordl_pkg::OP_TAIL;
                  count_in = count_ff + CW'(1);
               end
            end
            ordl_pkg::CMD_DELETE: begin
               ctrl.op = ordl_pkg::OP_DELETE;
               if (found) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  status_in = ordl_pkg::ST_MISSING;
               end
            end
            ordl_pkg::CMD_DUMP: begin
               if (count_ff == '0) begin
                  status_in = ordl_pkg::ST_EMPTY;
               end else begin
                  ctrl.op      = ordl_pkg::OP_ROTATE;
                  item_in      = cell_value[0];
                  last_in      = (count_ff == CW'(1));
                  remaining_in = count_ff - CW'(1);
               end
            end
            default: begin
               status_in = ordl_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_value = item_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   import ordl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_CMDS = 300;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] value;
      bit          drain;
   } list_cmd_type;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
      logic        last;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_cmd = 2'd0;
   logic [31:0] req_value = 32'd0;
   wire logic   busy;
   wire logic   rsp_valid;
   wire logic [31:0] rsp_item_value;
   wire logic [1:0]  rsp_status;
   wire logic   rsp_last;

   list_cmd_type pending_cmds[$];
   word_type     expected_words[$];
   logic [31:0]  list_words[CAPACITY];
   logic [31:0]  value_pool[6];
   int           list_len = 0;
   int           outstanding = 0;
   int           n_sent = 0;
   int           n_cmds = 0;
   int           n_words = 0;
   int           n_dumps = 0;
   int           n_full = 0;
   int           n_missing = 0;
   int           n_empty = 0;
   int           n_errors = 0;
   int           cycle_count = 0;
   word_type     got_word;
   word_type     want_word;

   ordered_list_engine_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      n_errors++;
   endtask

   task automatic expect_word(input logic [31:0] v, input status_type st, input logic fin);
      word_type w;
      w.value = v;
      w.status = st;
      w.last = fin;
      expected_words.push_back(w);
   endtask

   task automatic apply_list_cmd(input cmd_type c, input logic [31:0] v);
      int k;
      int hit;
      n_cmds++;
      case (c)
         CMD_HEAD, CMD_TAIL: begin
            if (list_len >= CAPACITY) begin
               expect_word(32'd0, ST_FULL, 1'b1);
               n_full++;
            end else begin
               if (c == CMD_HEAD) begin
                  for (k = list_len; k > 0; k--) list_words[k] = list_words[k-1];
                  list_words[0] = v;
               end else begin
                  list_words[list_len] = v;
               end
               list_len++;
               expect_word(32'd0, ST_OK, 1'b1);
            end
         end
         CMD_DELETE: begin
            hit = -1;
            for (k = 0; k < list_len; k++)
               if (hit < 0 && list_words[k] == v) hit = k;
            if (hit >= 0) begin
               for (k = hit; k < list_len - 1; k++) list_words[k] = list_words[k+1];
               list_len--;
               expect_word(32'd0, ST_OK, 1'b1);
            end else begin
               expect_word(32'd0, ST_MISSING, 1'b1);
               n_missing++;
            end
         end
         default: begin
            n_dumps++;
            if (list_len == 0) begin
               expect_word(32'd0, ST_EMPTY, 1'b1);
               n_empty++;
            end else begin
               for (k = 0; k < list_len; k++)
                  expect_word(list_words[k], ST_OK, k == list_len - 1);
            end
         end
      endcase
   endtask

   task automatic add_cmd(input cmd_type c, input logic [31:0] v, input bit drain);
      list_cmd_type item;
      item.cmd = c;
      item.value = v;
      item.drain = drain;
      pending_cmds.push_back(item);
   endtask

   function automatic logic [31:0] pick_value();
      if ($urandom_range(99) < 65) return value_pool[$urandom_range(5)];
      return $urandom;
   endfunction

   task automatic refresh_pool();
      int k;
      for (k = 0; k < 6; k++) value_pool[k] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
   endtask

   // driver
   always @(posedge clock) begin
      list_cmd_type next;
      bit idle;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) n_sent++;
         idle = ($urandom_range(99) < 19) && !(n_sent >= 120 && n_sent < 200);
         if (pending_cmds.size() > 0 && !idle &&
             !(pending_cmds[0].drain && (start || outstanding != 0))) begin
            next = pending_cmds.pop_front();
            start <= 1'b1;
            req_cmd <= next.cmd;
            req_value <= next.value;
         end else begin
            start <= 1'b0;
            req_cmd <= 2'($urandom_range(3));
            req_value <= $urandom;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         expected_words.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            got_word.value = rsp_item_value;
            got_word.status = status_type'(rsp_status);
            got_word.last = rsp_last;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word value=%h status=%0d last=%0b",
                                         rsp_item_value, rsp_status, rsp_last));
            end else begin
               want_word = expected_words.pop_front();
               n_words++;
               if (got_word !== want_word)
                  report_mismatch($sformatf(
                     "got value=%h status=%0d last=%0b, want value=%h status=%0d last=%0b",
                     rsp_item_value, rsp_status, rsp_last,
                     want_word.value, want_word.status, want_word.last));
            end
         end
         if (start && !busy) apply_list_cmd(cmd_type'(req_cmd), req_value);
         outstanding <= expected_words.size();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int n;
      int k;
      int mode;
      int roll;
      cmd_type c;

      add_cmd(CMD_DUMP, 32'd0, 1'b0);
      add_cmd(CMD_DELETE, 32'h0000_0005, 1'b0);
      add_cmd(CMD_HEAD, 32'h7fff_ffff, 1'b0);
      add_cmd(CMD_TAIL, 32'h8000_0000, 1'b0);
      add_cmd(CMD_HEAD, 32'h0000_0000, 1'b0);
      add_cmd(CMD_TAIL, 32'hffff_ffff, 1'b0);
      add_cmd(CMD_HEAD, 32'h8000_0000, 1'b0);
      add_cmd(CMD_DELETE, 32'h8000_0000, 1'b0);
      add_cmd(CMD_DELETE, 32'h7fff_fffe, 1'b0);
      add_cmd(CMD_DUMP, 32'hffff_ffff, 1'b0);
      for (k = 0; k < 12; k++)
         add_cmd(k[0] ? CMD_TAIL : CMD_HEAD, $urandom, k == 0);
      add_cmd(CMD_HEAD, 32'h1234_5678, 1'b0);
      add_cmd(CMD_TAIL, 32'h8765_4321, 1'b0);
      add_cmd(CMD_DUMP, 32'd0, 1'b0);
      add_cmd(CMD_DELETE, 32'hffff_ffff, 1'b0);

      for (n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 50 == 0) begin
            mode = (n / 50) % 3;
            refresh_pool();
         end
         roll = $urandom_range(99);
         case (mode)
            0: c = (roll < 70) ? ($urandom_range(1) ? CMD_TAIL : CMD_HEAD) :
                   (roll < 85) ? CMD_DELETE : CMD_DUMP;
            1: c = (roll < 65) ? CMD_DELETE :
                   (roll < 80) ? ($urandom_range(1) ? CMD_TAIL : CMD_HEAD) : CMD_DUMP;
            default: c = cmd_type'($urandom_range(3));
         endcase
         add_cmd(c, pick_value(), n % 75 == 37);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_cmds.size() != 0 || start) @(negedge clock);
      k = 0;
      while (outstanding != 0 && k < 200) begin
         @(negedge clock);
         k++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));

      $display("ran %0d commands, checked %0d result words over %0d dumps",
               n_cmds, n_words, n_dumps);
      $display("saw %0d full rejects, %0d missed deletes, %0d empty dumps, %0d errors",
               n_full, n_missing, n_empty, n_errors);
      if (n_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
